// ----- src/tcag_pkg.sv -----
`default_nettype none

package tcag_pkg;

	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_REGS    = 8;
	localparam int NDIM        = 4;
	localparam int ADDR_OUT_W  = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam int DEF_MAX_DIM   = 4096;
	localparam int DEF_ADDR_BITS = 32;

	// coordinate slots, outermost first
	localparam int DIM_N = 0;
	localparam int DIM_C = 1;
	localparam int DIM_H = 2;
	localparam int DIM_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_BATCH,
		REG_IN_CHANNELS,
		REG_IN_HEIGHT,
		REG_IN_WIDTH,
		REG_OUT_BATCH,
		REG_OUT_CHANNELS,
		REG_OUT_HEIGHT,
		REG_OUT_WIDTH
	} cfg_reg_t;

	typedef struct packed {
		logic idle;
		logic last;
	} flags_t;

	// largest size a 13-bit register can reach after the clamp
	function automatic int dim_limit(input int max_dim);
		return (max_dim < (2 ** CFG_W) - 1) ? max_dim : (2 ** CFG_W) - 1;
	endfunction

	function automatic int dim_w(input int max_dim);
		return $clog2(dim_limit(max_dim) + 1);
	endfunction

	function automatic int coord_w(input int max_dim);
		return $clog2(dim_limit(max_dim));
	endfunction

	// zero reads as one, anything above the limit reads as the limit
	function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
			input int max_dim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (int'(v) > max_dim) begin
			r = CFG_W'(max_dim);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/tile_c4_address_generator_unit.sv -----
`default_nettype none

// Channel    Handshake               Payload
// cfg        cfg_we                  cfg_index, cfg_data
// in         in_valid / in_ready     restart
// out        out_valid / out_ready   src_addr, dst_addr, last, idle
//
// One request per cycle unless the output stalls; each request gives one result word.
// The front steps the coordinate counters in the cycle a request is taken; the
// result leaves through the queue, three multiply/add stages and the output register.
// A four-entry queue lets requests in while the output is stalled.
// Reset sets all sizes to one, clears the walk and leaves the pass idle.

module tile_c4_address_generator_unit #(
	parameter int MAX_DIM   = tcag_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tcag_pkg::DEF_ADDR_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [tcag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tcag_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               restart,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [tcag_pkg::ADDR_OUT_W-1:0]         src_addr,
	output logic [tcag_pkg::ADDR_OUT_W-1:0]         dst_addr,
	output logic                                    last,
	output logic                                    idle
);

	localparam int NDIM = tcag_pkg::NDIM;
	localparam int DW   = tcag_pkg::dim_w(MAX_DIM);
	localparam int CW   = tcag_pkg::coord_w(MAX_DIM);
	localparam int QW   = $bits(tcag_pkg::flags_t) + 2 * NDIM * CW;

	logic [tcag_pkg::CFG_W-1:0] cfg_q [tcag_pkg::NUM_REGS];
	logic [NDIM-1:0][DW-1:0]    idim;
	logic [NDIM-1:0][DW-1:0]    odim;

	logic                       push_valid;
	logic                       push_ready;
	logic [QW-1:0]              push_data;
	logic                       pop_valid;
	logic                       pop_ready;
	logic [QW-1:0]              pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tcag_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= tcag_pkg::CFG_W'(1);
			end
		end else if (cfg_we) begin
			unique case (tcag_pkg::cfg_reg_t'(cfg_index))
				tcag_pkg::REG_IN_BATCH:     cfg_q[tcag_pkg::REG_IN_BATCH]     <= cfg_data;
				tcag_pkg::REG_IN_CHANNELS:  cfg_q[tcag_pkg::REG_IN_CHANNELS]  <= cfg_data;
				tcag_pkg::REG_IN_HEIGHT:    cfg_q[tcag_pkg::REG_IN_HEIGHT]    <= cfg_data;
				tcag_pkg::REG_IN_WIDTH:     cfg_q[tcag_pkg::REG_IN_WIDTH]     <= cfg_data;
				tcag_pkg::REG_OUT_BATCH:    cfg_q[tcag_pkg::REG_OUT_BATCH]    <= cfg_data;
				tcag_pkg::REG_OUT_CHANNELS: cfg_q[tcag_pkg::REG_OUT_CHANNELS] <= cfg_data;
				tcag_pkg::REG_OUT_HEIGHT:   cfg_q[tcag_pkg::REG_OUT_HEIGHT]   <= cfg_data;
				tcag_pkg::REG_OUT_WIDTH:    cfg_q[tcag_pkg::REG_OUT_WIDTH]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// source sizes sit in the first four registers, result sizes in the next four
	always_comb begin
		for (int i = 0; i < NDIM; i++) begin
			idim[i] = DW'(tcag_pkg::eff_dim(cfg_q[i], MAX_DIM));
			odim[i] = DW'(tcag_pkg::eff_dim(cfg_q[NDIM + i], MAX_DIM));
		end
	end

	tcag_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.idim       (idim),
		.odim       (odim),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tcag_fifo #(
		.W     (QW),
		.DEPTH (tcag_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tcag_back #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.idim      (idim),
		.odim      (odim),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.src_addr  (src_addr),
		.dst_addr  (dst_addr),
		.last      (last),
		.idle      (idle)
	);

endmodule

`default_nettype wire

// ----- src/tcag_fifo.sv -----
`default_nettype none

module tcag_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = tcag_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tcag_front.sv -----
`default_nettype none

module tcag_front #(
	parameter int MAX_DIM = tcag_pkg::DEF_MAX_DIM,
	localparam int DW = tcag_pkg::dim_w(MAX_DIM),
	localparam int CW = tcag_pkg::coord_w(MAX_DIM),
	localparam int QW = $bits(tcag_pkg::flags_t) + 2 * tcag_pkg::NDIM * CW
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                restart,
	input  wire logic [tcag_pkg::NDIM-1:0][DW-1:0]   idim,
	input  wire logic [tcag_pkg::NDIM-1:0][DW-1:0]   odim,
	output logic                                     push_valid,
	input  wire logic                                push_ready,
	output logic [QW-1:0]                            push_data
);

	localparam int NDIM = tcag_pkg::NDIM;

	logic [NDIM-1:0][CW-1:0] oc_q;
	logic [NDIM-1:0][CW-1:0] sc_q;
	logic                    active_q;

	logic [NDIM-1:0][CW-1:0] oc_n;
	logic [NDIM-1:0][CW-1:0] sc_n;
	logic                    is_last;
	tcag_pkg::flags_t        flags;
	logic                    accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// step the walk: innermost dimension first, carry outward; restart clears it
	always_comb begin
		logic carry;
		logic owrap;
		logic swrap;
		oc_n  = oc_q;
		sc_n  = sc_q;
		carry = 1'b1;
		owrap = 1'b0;
		swrap = 1'b0;
		if (restart) begin
			oc_n = '0;
			sc_n = '0;
		end else begin
			for (int i = NDIM - 1; i >= 0; i--) begin
				if (carry) begin
					owrap = ((DW+1)'(oc_q[i]) + (DW+1)'(1)) >= (DW+1)'(odim[i]);
					swrap = ((DW+1)'(sc_q[i]) + (DW+1)'(1)) >= (DW+1)'(idim[i]);
					if (owrap) begin
						oc_n[i] = '0;
						sc_n[i] = '0;
					end else begin
						oc_n[i] = CW'(oc_q[i] + 1'b1);
						sc_n[i] = swrap ? '0 : CW'(sc_q[i] + 1'b1);
						carry   = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		is_last = 1'b1;
		for (int i = 0; i < NDIM; i++) begin
			if (((DW+1)'(oc_n[i]) + (DW+1)'(1)) < (DW+1)'(odim[i])) begin
				is_last = 1'b0;
			end
		end
	end

	always_comb begin
		flags.idle = !restart && !active_q;
		flags.last = is_last && !flags.idle;
	end

	assign push_data = {flags, sc_n, oc_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q     <= '0;
			sc_q     <= '0;
			active_q <= 1'b0;
		end else if (accept && (restart || active_q)) begin
			oc_q     <= oc_n;
			sc_q     <= sc_n;
			active_q <= !is_last;
		end
	end

endmodule

`default_nettype wire

// ----- src/tcag_addr.sv -----
`default_nettype none

module tcag_addr #(
	parameter int MAX_DIM   = tcag_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tcag_pkg::DEF_ADDR_BITS,
	localparam int DW = tcag_pkg::dim_w(MAX_DIM),
	localparam int CW = tcag_pkg::coord_w(MAX_DIM)
) (
	input  wire logic                                clk,
	input  wire logic                                adv,
	input  wire logic [tcag_pkg::NDIM-1:0][CW-1:0]   coord,
	input  wire logic [DW-1:0]                       dim_c,
	input  wire logic [DW-1:0]                       dim_h,
	input  wire logic [DW-1:0]                       dim_w,
	output logic [ADDR_BITS-1:0]                     addr
);

	localparam int PW  = 2 * DW;
	localparam int NRW = CW + DW + 1;
	localparam int HWW = CW + DW;
	localparam int LOW = HWW + 1;

	logic [DW:0]            r4c;
	logic [PW-1:0]          plane;
	logic [NRW-1:0]         nr;
	logic [HWW-1:0]         hw;
	logic [NRW+PW-1:0]      prod_batch;
	logic [CW+PW-1:0]       prod_blk;
	logic [LOW-1:0]         lo;

	logic [PW-1:0]          plane_s1;
	logic [NRW-1:0]         nr_s1;
	logic [HWW-1:0]         hw_s1;
	logic [CW-1:0]          w_s1;
	logic [CW-1:0]          cblk_s1;
	logic [1:0]             lane_s1;

	logic [ADDR_BITS-1:0]   batch_s2;
	logic [ADDR_BITS-1:0]   blk_s2;
	logic [ADDR_BITS-1:0]   spat_s2;

	logic [ADDR_BITS-1:0]   sum_s3;

	// channels rounded up to a whole block of four lanes
	assign r4c   = ((DW+1)'(dim_c) + (DW+1)'(3)) & ~(DW+1)'(3);
	assign plane = dim_h * dim_w;
	assign nr    = coord[tcag_pkg::DIM_N] * r4c;
	assign hw    = coord[tcag_pkg::DIM_H] * dim_w;

	assign prod_batch = nr_s1 * plane_s1;
	assign prod_blk   = cblk_s1 * plane_s1;
	assign lo         = LOW'(hw_s1) + LOW'(w_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s1 <= plane;
			nr_s1    <= nr;
			hw_s1    <= hw;
			w_s1     <= coord[tcag_pkg::DIM_W];
			cblk_s1  <= coord[tcag_pkg::DIM_C] >> 2;
			lane_s1  <= 2'(coord[tcag_pkg::DIM_C]);

			batch_s2 <= ADDR_BITS'(prod_batch);
			blk_s2   <= ADDR_BITS'(prod_blk);
			spat_s2  <= ADDR_BITS'({lo, lane_s1});

			sum_s3   <= batch_s2 + (blk_s2 << 2) + spat_s2;
		end
	end

	assign addr = sum_s3;

endmodule

`default_nettype wire

// ----- src/tcag_back.sv -----
`default_nettype none

module tcag_back #(
	parameter int MAX_DIM   = tcag_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tcag_pkg::DEF_ADDR_BITS,
	localparam int DW = tcag_pkg::dim_w(MAX_DIM),
	localparam int CW = tcag_pkg::coord_w(MAX_DIM),
	localparam int QW = $bits(tcag_pkg::flags_t) + 2 * tcag_pkg::NDIM * CW
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pop_valid,
	output logic                                     pop_ready,
	input  wire logic [QW-1:0]                       pop_data,
	input  wire logic [tcag_pkg::NDIM-1:0][DW-1:0]   idim,
	input  wire logic [tcag_pkg::NDIM-1:0][DW-1:0]   odim,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [tcag_pkg::ADDR_OUT_W-1:0]          src_addr,
	output logic [tcag_pkg::ADDR_OUT_W-1:0]          dst_addr,
	output logic                                     last,
	output logic                                     idle
);

	localparam int NDIM  = tcag_pkg::NDIM;
	localparam int OUT_W = tcag_pkg::ADDR_OUT_W;

	tcag_pkg::flags_t        q_flags;
	logic [NDIM-1:0][CW-1:0] q_src;
	logic [NDIM-1:0][CW-1:0] q_dst;
	logic                    adv;
	logic [ADDR_BITS-1:0]    src_raw;
	logic [ADDR_BITS-1:0]    dst_raw;

	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	tcag_pkg::flags_t        flags_s1;
	tcag_pkg::flags_t        flags_s2;
	tcag_pkg::flags_t        flags_s3;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        src_addr_q;
	logic [OUT_W-1:0]        dst_addr_q;
	tcag_pkg::flags_t        flags_q;

	assign {q_flags, q_src, q_dst} = pop_data;

	// whole pipe moves together whenever the output register can take a word
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;

	tcag_addr #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_src (
		.clk   (clk),
		.adv   (adv),
		.coord (q_src),
		.dim_c (idim[tcag_pkg::DIM_C]),
		.dim_h (idim[tcag_pkg::DIM_H]),
		.dim_w (idim[tcag_pkg::DIM_W]),
		.addr  (src_raw)
	);

	tcag_addr #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_dst (
		.clk   (clk),
		.adv   (adv),
		.coord (q_dst),
		.dim_c (odim[tcag_pkg::DIM_C]),
		.dim_h (odim[tcag_pkg::DIM_H]),
		.dim_w (odim[tcag_pkg::DIM_W]),
		.addr  (dst_raw)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= q_flags;
			flags_s2 <= flags_s1;
			flags_s3 <= flags_s2;
			flags_q  <= flags_s3;
			// idle requests report zero addresses
			src_addr_q <= flags_s3.idle ? '0 : OUT_W'(src_raw);
			dst_addr_q <= flags_s3.idle ? '0 : OUT_W'(dst_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign src_addr  = src_addr_q;
	assign dst_addr  = dst_addr_q;
	assign last      = flags_q.last;
	assign idle      = flags_q.idle;

endmodule

`default_nettype wire
